FILE: rtl/segment_fit_allocator_core_macros.svh
// Assertion macros used by the checker file.
`ifndef SEGMENT_FIT_ALLOCATOR_CORE_MACROS_SVH
`define SEGMENT_FIT_ALLOCATOR_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// Segment fit allocator package
// Shared widths, status codes and the segment entry type.
// ----------------------------------------------------------------------------
package sfa_pkg;
	localparam int MaxSegments = 64;
	localparam int AddrBits    = 16;
	localparam int IdBits      = 8;
	localparam int IdxBits     = $clog2(MaxSegments);
	localparam int CntBits     = $clog2(MaxSegments + 1);

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOFIT   = 3'd1;
	localparam logic [2:0] ST_NOOWNER = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_ZERO    = 3'd4;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic CFG_STRATEGY = 1'b0;
	localparam logic CFG_MEMSIZE  = 1'b1;

	typedef struct packed {
		logic [AddrBits-1:0] start;
		logic [AddrBits-1:0] len;
		logic                used;
		logic [IdBits-1:0]   owner;
	} seg_t;
endpackage

FILE: rtl/segment_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// Segment fit allocator core
// Address-ordered segment table with first, best or worst fit and merging.
// ----------------------------------------------------------------------------
// An item takes up to three passes over the table, each reading one
// entry a cycle from the table memory: scan, shift and statistics for an
// allocation, release, merge and statistics for a free. One item is
// worked on at a time; busy is high meanwhile. Reset clears control state
// and gives one free segment spanning 65535 bytes. The strobe lasts one
// cycle.
module segment_fit_allocator_core
	import sfa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                op,
	input  logic [IdBits-1:0]   owner_id,
	input  logic [15:0]         request_size,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                result_valid,
	output logic [2:0]          status,
	output logic [15:0]         start_address,
	output logic [15:0]         used_total,
	output logic [15:0]         free_total,
	output logic [15:0]         largest_free,
	output logic [6:0]          free_count
);
	// The controller walks the table with a read pointer. Every table rewrite
	// (split, release, merge) is a pass that reads entries in order: a release
	// rewrites them in place, a merge writes to a trailing write pointer.
	// Splits shift the tail up one place, so that pass runs from the top down.
	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SCAN   = 10'b0000000010,
		S_DECIDE = 10'b0000000100,
		S_SHIFT  = 10'b0000001000,
		S_PLACE  = 10'b0000010000,
		S_FREE   = 10'b0000100000,
		S_MERGE  = 10'b0001000000,
		S_STATS  = 10'b0010000000,
		S_DONE   = 10'b0100000000,
		S_INIT   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [1:0]         strategy_q;
	logic [15:0]        memsize_q;
	logic [CntBits-1:0] count_q;
	logic               op_q;
	logic [IdBits-1:0]  owner_q;
	logic [15:0]        size_q;

	// Read pointer and a delayed copy: data for the address issued in one
	// cycle arrives in the next.
	logic [CntBits-1:0] rptr_q;
	logic [CntBits-1:0] rptr_d1_q;
	logic               rvalid_q;
	logic [CntBits-1:0] wptr_q;

	logic               found_q;
	logic [IdxBits-1:0] pick_q;
	seg_t               pick_seg_q;
	logic [2:0]         status_q;
	logic [15:0]        addr_q;

	// Merge accumulator: the entry being built before it is written out.
	seg_t               acc_q;
	logic               acc_valid_q;

	logic [15:0]        used_q;
	logic [15:0]        freet_q;
	logic [15:0]        big_q;
	logic [6:0]         nfree_q;

	logic               wr_en;
	logic [IdxBits-1:0] wr_addr;
	seg_t               wr_data;
	logic [IdxBits-1:0] rd_addr;
	seg_t               rd_data;

	sfa_seg_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// A start item takes precedence over a register write in the idle state,
	// so the write channel is held off whenever start is high.
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign rd_addr   = rptr_q[IdxBits-1:0];

	logic fits;
	logic better;
	logic [15:0] rem;
	assign fits = rvalid_q && !rd_data.used && (rd_data.len >= size_q);
	always_comb begin
		case (strategy_q)
			FIT_FIRST: better = !found_q;
			FIT_BEST:  better = !found_q || (rd_data.len < pick_seg_q.len);
			FIT_WORST: better = !found_q || (rd_data.len > pick_seg_q.len);
			default:   better = 1'b0;
		endcase
	end
	assign rem = pick_seg_q.len - size_q;

	logic owned;
	assign owned = rd_data.used && (rd_data.owner == owner_q);

	// Memory write port.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wptr_q[IdxBits-1:0];
		wr_data = rd_data;
		case (state_q)
			S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '{start: '0, len: memsize_q, used: 1'b0, owner: '0};
			end
			S_SHIFT: begin
				// Move entry read earlier one place up.
				wr_en   = rvalid_q;
				wr_addr = IdxBits'(rptr_d1_q + 1'b1);
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pick_q;
				wr_data = '{start: pick_seg_q.start, len: size_q, used: 1'b1,
					owner: owner_q};
				if (wptr_q[0]) begin
					wr_addr = IdxBits'({1'b0, pick_q} + 1'b1);
					wr_data = '{start: pick_seg_q.start + size_q, len: rem,
						used: 1'b0, owner: '0};
				end
			end
			S_FREE: begin
				wr_en   = rvalid_q && owned;
				wr_addr = rptr_d1_q[IdxBits-1:0];
				wr_data = '{start: rd_data.start, len: rd_data.len, used: 1'b0,
					owner: '0};
			end
			S_MERGE: begin
				// Flush the accumulator when the next entry cannot join it.
				wr_en   = acc_valid_q && (!rvalid_q || acc_q.used || rd_data.used);
				wr_data = acc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			strategy_q   <= FIT_FIRST;
			memsize_q    <= 16'hFFFF;
			count_q      <= CntBits'(1);
			result_valid <= 1'b0;
			rptr_q       <= '0;
			rvalid_q     <= 1'b0;
			wptr_q       <= '0;
			found_q      <= 1'b0;
			acc_valid_q  <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			rptr_d1_q    <= rptr_q;
			rvalid_q     <= 1'b0;
			case (state_q)
				S_INIT: begin
					count_q <= CntBits'(1);
					rptr_q  <= '0;
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q     <= op;
						owner_q  <= owner_id;
						size_q   <= request_size;
						found_q  <= 1'b0;
						addr_q   <= '0;
						rptr_q   <= CntBits'(1);
						rvalid_q <= 1'b1;
						if (op) begin
							status_q <= ST_NOOWNER;
							state_q  <= S_FREE;
							rptr_q   <= CntBits'(1);
						end else if (request_size == '0) begin
							status_q <= ST_ZERO;
							rptr_q   <= '0;
							rvalid_q <= 1'b0;
							state_q  <= S_STATS;
							used_q   <= '0;
							freet_q  <= '0;
							big_q    <= '0;
							nfree_q  <= '0;
						end else begin
							status_q <= ST_NOFIT;
							state_q  <= S_SCAN;
						end
					end else if (cfg_valid) begin
						if (cfg_index == CFG_STRATEGY) begin
							strategy_q <= cfg_data[1:0];
						end else begin
							memsize_q <= cfg_data;
							state_q   <= S_INIT;
						end
					end
				end
				S_SCAN: begin
					if (fits && better) begin
						found_q    <= 1'b1;
						pick_q     <= rptr_d1_q[IdxBits-1:0];
						pick_seg_q <= rd_data;
					end
					if (rptr_q < count_q) begin
						rptr_q   <= rptr_q + 1'b1;
						rvalid_q <= 1'b1;
					end else if (!rvalid_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!found_q) begin
						status_q <= ST_NOFIT;
						state_q  <= S_STATS;
					end else if (rem != '0 && count_q == CntBits'(MaxSegments)) begin
						status_q <= ST_FULL;
						state_q  <= S_STATS;
					end else if (rem != '0) begin
						// Shift entries above the pick, top first. The first
						// read is issued in the shift state itself.
						rptr_q   <= count_q - 1'b1;
						state_q  <= S_SHIFT;
					end else begin
						wptr_q  <= '0;
						state_q <= S_PLACE;
					end
					if (!found_q || (rem != '0 && count_q == CntBits'(MaxSegments))) begin
						rptr_q   <= '0;
						rvalid_q <= 1'b0;
						used_q   <= '0;
						freet_q  <= '0;
						big_q    <= '0;
						nfree_q  <= '0;
					end
				end
				S_SHIFT: begin
					// Each cycle reads the entry at the pointer while it lies
					// above the pick; the write of the previous read trails it.
					if (rptr_q > {1'b0, pick_q}) begin
						rptr_q   <= rptr_q - 1'b1;
						rvalid_q <= 1'b1;
					end else if (!rvalid_q) begin
						count_q <= count_q + 1'b1;
						wptr_q  <= CntBits'(1);
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					// wptr bit 0 set: split remainder still to write.
					addr_q   <= pick_seg_q.start;
					status_q <= ST_OK;
					wptr_q   <= '0;
					if (!wptr_q[0]) begin
						rptr_q  <= '0;
						used_q  <= '0;
						freet_q <= '0;
						big_q   <= '0;
						nfree_q <= '0;
						state_q <= S_STATS;
					end
				end
				S_FREE: begin
					if (rvalid_q && owned) begin
						status_q <= ST_OK;
					end
					if (rptr_q < count_q) begin
						rptr_q   <= rptr_q + 1'b1;
						rvalid_q <= 1'b1;
					end else if (!rvalid_q) begin
						// The next pass issues its first read from entry zero.
						rptr_q      <= '0;
						rvalid_q    <= 1'b0;
						wptr_q      <= '0;
						acc_valid_q <= 1'b0;
						if (status_q == ST_OK) begin
							state_q <= S_MERGE;
						end else begin
							used_q   <= '0;
							freet_q  <= '0;
							big_q    <= '0;
							nfree_q  <= '0;
							state_q  <= S_STATS;
						end
					end
				end
				S_MERGE: begin
					if (wr_en) begin
						wptr_q <= wptr_q + 1'b1;
					end
					if (rvalid_q) begin
						if (acc_valid_q && !acc_q.used && !rd_data.used) begin
							acc_q.len <= acc_q.len + rd_data.len;
						end else begin
							acc_q <= rd_data;
						end
						acc_valid_q <= 1'b1;
					end else begin
						acc_valid_q <= 1'b0;
					end
					if (rptr_q < count_q) begin
						rptr_q   <= rptr_q + 1'b1;
						rvalid_q <= 1'b1;
					end else if (!rvalid_q && !acc_valid_q) begin
						count_q  <= wptr_q;
						rptr_q   <= '0;
						used_q   <= '0;
						freet_q  <= '0;
						big_q    <= '0;
						nfree_q  <= '0;
						state_q  <= S_STATS;
					end
				end
				S_STATS: begin
					if (rvalid_q) begin
						if (rd_data.used) begin
							used_q <= used_q + rd_data.len;
						end else begin
							freet_q <= freet_q + rd_data.len;
							nfree_q <= nfree_q + 1'b1;
							if (rd_data.len > big_q) begin
								big_q <= rd_data.len;
							end
						end
					end
					if (rptr_q < count_q) begin
						rptr_q   <= rptr_q + 1'b1;
						rvalid_q <= 1'b1;
					end else if (!rvalid_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Park the read pointer on entry zero for the next item.
					result_valid <= 1'b1;
					rptr_q       <= '0;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status        = status_q;
	assign start_address = addr_q;
	assign used_total    = used_q;
	assign free_total    = freet_q;
	assign largest_free  = big_q;
	assign free_count    = nfree_q;
endmodule

FILE: rtl/sfa_seg_ram.sv
// ----------------------------------------------------------------------------
// Segment table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfa_seg_ram
	import sfa_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IdxBits-1:0] wr_addr,
	input  seg_t               wr_data,
	input  logic [IdxBits-1:0] rd_addr,
	output seg_t               rd_data
);
	seg_t mem [MaxSegments];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: rtl/sfa_checker.sv
// ----------------------------------------------------------------------------
// Segment fit allocator port checker
// Watches the top-level ports for command and result ordering.
// ----------------------------------------------------------------------------
`include "segment_fit_allocator_core_macros.svh"
module sfa_checker
	import sfa_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       cfg_ready,
	input logic       result_valid,
	input logic [2:0] status,
	input logic [15:0] start_address
);
	`SFA_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`SFA_ASSERT_IMPL(a_result_idle, clk, arst_n, result_valid, !busy)
	`SFA_ASSERT_NEXT(a_one_shot, clk, arst_n, result_valid, !result_valid)
	`SFA_ASSERT_IMPL(a_addr_zero, clk, arst_n, result_valid && status != ST_OK,
		start_address == '0)
	`SFA_ASSERT_IMPL(a_cfg_idle, clk, arst_n, cfg_ready, !busy && !start)
endmodule

bind segment_fit_allocator_core sfa_checker u_sfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cfg_ready     (cfg_ready),
	.result_valid  (result_valid),
	.status        (status),
	.start_address (start_address)
);
